>>> design/ssi_pkg.sv
// Package for the sorted set intersection block: types, codes and defaults.
`default_nettype none

package ssi_pkg;

   // Default sizes, taken by the top-level parameters
   localparam int MAX_SET_SIZE_DEFAULT  = 64;
   localparam int ELEMENT_WIDTH_DEFAULT = 32;

   // Fixed field widths of the request and result
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   // Request opcodes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_PROBE  = 1'b1;

   // Request payload
   typedef struct packed {
      logic                      op;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   // Result payload
   typedef struct packed {
      logic                      found;
      logic signed [VALUE_W-1:0] element;
      logic [COUNT_W-1:0]        match_count;
      logic                      final_res;
      logic                      overflow;
   } rsp_type;

   // Controls broadcast from the sequencer to every cell of the chain
   typedef struct packed {
      logic pop;    // shift the whole chain one cell toward the head
      logic load;   // write the appended element into the selected cell
   } chain_ctl_type;

endpackage

`default_nettype wire

>>> design/ssi_cell.sv
// One cell of the element chain: holds one stored set A element.
`default_nettype none

module ssi_cell
   import ssi_pkg::*;
#(
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire chain_ctl_type                   ctl,
   input  wire logic                            load_sel,
   input  wire logic signed [ELEMENT_WIDTH-1:0] load_value,
   input  wire logic signed [ELEMENT_WIDTH-1:0] next_value,
   output logic signed [ELEMENT_WIDTH-1:0]      value
);

   logic signed [ELEMENT_WIDTH-1:0] value_ff;
   logic signed [ELEMENT_WIDTH-1:0] value_in;

   // Shift from the neighbor on pop, else take an append aimed at this cell
   always_comb begin
      value_in = value_ff;
      if (ctl.pop) begin
         value_in = next_value;
      end else if (ctl.load && load_sel) begin
         value_in = load_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

>>> design/ssi_ctrl.sv
// Sequencer: counters, merge scan against the chain head, result register.
`default_nettype none

module ssi_ctrl
   import ssi_pkg::*;
#(
   parameter int MAX_SET_SIZE  = MAX_SET_SIZE_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT,
   localparam int CNT_W        = $clog2(MAX_SET_SIZE + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            req_op,
   input  wire logic                            req_last,
   input  wire logic signed [ELEMENT_WIDTH-1:0] req_elem,
   input  wire logic signed [ELEMENT_WIDTH-1:0] head_value,
   output logic                                 busy,
   output chain_ctl_type                        ctl,
   output logic [CNT_W-1:0]                     fill,
   output logic                                 rsp_strobe,
   output rsp_type                              rsp_data
);

   typedef enum logic {
      IDLE,
      SCAN
   } state_type;

   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                stored_ff, stored_in;
   logic [CNT_W-1:0]                fill_ff, fill_in;
   logic [CNT_W-1:0]                matches_ff, matches_in;
   logic                            dropped_ff, dropped_in;
   logic signed [ELEMENT_WIDTH-1:0] probe_ff, probe_in;
   logic                            last_ff, last_in;
   logic                            rsp_strobe_ff, rsp_strobe_in;
   rsp_type                         rsp_ff, rsp_in;
   chain_ctl_type                   ctl_c;
   logic                            have_c;
   logic                            found_c;

   // Next-state logic for appends and the merge scan
   always_comb begin
      state_in      = state_ff;
      stored_in     = stored_ff;
      fill_in       = fill_ff;
      matches_in    = matches_ff;
      dropped_in    = dropped_ff;
      probe_in      = probe_ff;
      last_in       = last_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ctl_c         = '0;
      have_c        = (fill_ff != '0);
      found_c       = 1'b0;

      case (state_ff)
         IDLE: begin
            if (start) begin
               if (req_op == OP_APPEND) begin
                  if (stored_ff == CNT_W'(MAX_SET_SIZE)) begin
                     dropped_in = 1'b1;
                  end else begin
                     ctl_c.load = 1'b1;
                     stored_in  = stored_ff + CNT_W'(1);
                     fill_in    = fill_ff + CNT_W'(1);
                  end
               end else begin
                  probe_in = req_elem;
                  last_in  = req_last;
                  state_in = SCAN;
               end
            end
         end
         SCAN: begin
            if (have_c && (head_value < probe_ff)) begin
               // skip a smaller stored element
               ctl_c.pop = 1'b1;
               fill_in   = fill_ff - CNT_W'(1);
            end else begin
               found_c = have_c && (head_value == probe_ff);
               if (found_c) begin
                  ctl_c.pop  = 1'b1;
                  fill_in    = fill_ff - CNT_W'(1);
                  matches_in = matches_ff + CNT_W'(1);
               end
               rsp_strobe_in      = 1'b1;
               rsp_in.found       = found_c;
               rsp_in.element     = VALUE_W'($unsigned(probe_ff));
               rsp_in.match_count = COUNT_W'(matches_in);
               rsp_in.final_res   = last_ff;
               rsp_in.overflow    = dropped_ff;
               // end of intersection clears the set
               if (last_ff) begin
                  stored_in  = '0;
                  fill_in    = '0;
                  matches_in = '0;
                  dropped_in = 1'b0;
               end
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State, counters and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         stored_ff     <= '0;
         fill_ff       <= '0;
         matches_ff    <= '0;
         dropped_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         stored_ff     <= stored_in;
         fill_ff       <= fill_in;
         matches_ff    <= matches_in;
         dropped_ff    <= dropped_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      probe_ff <= probe_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != IDLE);
   assign ctl        = ctl_c;
   assign fill       = fill_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

>>> design/sorted_set_intersection.sv
// An append leaves busy low and gives no result; up to one append per cycle is taken.
// A probe keeps busy high while the scan skips the stored elements below it, one chain
// comparison per cycle; the result strobes in the same cycle that busy falls. Requests
// are taken only while busy is low. The receiver cannot stall the result.
// Reset (synchronous) empties the set and clears all counts; stored values are not cleared.
`default_nettype none

module sorted_set_intersection
   import ssi_pkg::*;
#(
   parameter int MAX_SET_SIZE  = MAX_SET_SIZE_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_data,
   output logic         busy,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(MAX_SET_SIZE + 1);

   chain_ctl_type                   ctl;
   logic [CNT_W-1:0]                fill;
   logic signed [ELEMENT_WIDTH-1:0] req_elem;
   logic signed [ELEMENT_WIDTH-1:0] cell_value [MAX_SET_SIZE];

   // Request value in element width, sign-extended or truncated
   assign req_elem = ELEMENT_WIDTH'(req_data.value);

   ssi_ctrl #(
      .MAX_SET_SIZE  (MAX_SET_SIZE),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_op     (req_data.op),
      .req_last   (req_data.last),
      .req_elem   (req_elem),
      .head_value (cell_value[0]),
      .busy       (busy),
      .ctl        (ctl),
      .fill       (fill),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Chain of cells: cell 0 is the merge pointer, pops shift toward it
   for (genvar i = 0; i < MAX_SET_SIZE; i++) begin : g_cell
      logic signed [ELEMENT_WIDTH-1:0] next_value;

      if (i == MAX_SET_SIZE - 1) begin : g_tail
         assign next_value = '0;
      end else begin : g_body
         assign next_value = cell_value[i+1];
      end

      ssi_cell #(
         .ELEMENT_WIDTH (ELEMENT_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .load_sel   (fill == CNT_W'(i)),
         .load_value (req_elem),
         .next_value (next_value),
         .value      (cell_value[i])
      );
   end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the sorted set intersection block.
`timescale 1ns / 100ps

module tb_top;
   import ssi_pkg::*;

   localparam int SET_CAP      = MAX_SET_SIZE_DEFAULT;
   localparam int ITEM_TARGET  = 1750;
   localparam int CALM_TAIL    = 250;
   localparam int DRAIN_CYCLES = 2 * SET_CAP + 20;
   localparam int CYCLE_LIMIT  = 1_000_000;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   // Tracks set A and the merge pointer, queues the result each probe must give
   class intersection_tracker;
      logic signed [VALUE_W-1:0] set_a[SET_CAP];
      int      stored;
      int      scan;
      int      hits;
      bit      dropped;
      rsp_type awaited_results[$];
      int      fail_count;

      function void note_request(req_type r);
         rsp_type exp;
         if (r.op == OP_APPEND) begin
            if (stored < SET_CAP) begin
               set_a[stored] = r.value;
               stored++;
            end else begin
               dropped = 1'b1;
            end
            return;
         end
         // skip stored elements below the probe, then test for equality
         while (scan < stored && $signed(set_a[scan]) < $signed(r.value))
            scan++;
         exp.found = 1'b0;
         if (scan < stored && set_a[scan] == r.value) begin
            exp.found = 1'b1;
            scan++;
            hits++;
         end
         exp.element     = r.value;
         exp.match_count = COUNT_W'(hits);
         exp.final_res   = r.last;
         exp.overflow    = dropped;
         awaited_results.insert(awaited_results.size(), exp);
         // end of intersection: counts clear after the result is formed
         if (r.last) begin
            stored  = 0;
            scan    = 0;
            hits    = 0;
            dropped = 1'b0;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (awaited_results.size() == 0) begin
            $display("%0t: result with none expected: expected nothing, got element %0d",
                     $time, got.element);
            fail_count++;
            return;
         end
         exp = awaited_results.pop_front();
         if (got.found !== exp.found) begin
            $display("%0t: found mismatch (element %0d): expected %0b, got %0b",
                     $time, exp.element, exp.found, got.found);
            fail_count++;
         end
         if (got.element !== exp.element) begin
            $display("%0t: element mismatch: expected %0d, got %0d",
                     $time, exp.element, got.element);
            fail_count++;
         end
         if (got.match_count !== exp.match_count) begin
            $display("%0t: match_count mismatch (element %0d): expected %0d, got %0d",
                     $time, exp.element, exp.match_count, got.match_count);
            fail_count++;
         end
         if (got.final_res !== exp.final_res) begin
            $display("%0t: final_res mismatch (element %0d): expected %0b, got %0b",
                     $time, exp.element, exp.final_res, got.final_res);
            fail_count++;
         end
         if (got.overflow !== exp.overflow) begin
            $display("%0t: overflow mismatch (element %0d): expected %0b, got %0b",
                     $time, exp.element, exp.overflow, got.overflow);
            fail_count++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   intersection_tracker tracker;
   int sent_count;
   int cycle_count;
   bit bursty;
   bit quiet_tail;

   sorted_set_intersection #(
      .MAX_SET_SIZE  (SET_CAP),
      .ELEMENT_WIDTH (ELEMENT_WIDTH_DEFAULT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** sorted_set_intersection: FAILED **");
         $finish;
      end
   end

   // Results cannot be held off: check each strobed cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         if (rsp_strobe !== 1'b1) begin
            $display("%0t: rsp_strobe unknown: expected 0 or 1, got %b", $time, rsp_strobe);
            tracker.fail_count++;
         end else begin
            tracker.check_result(rsp_data);
         end
      end
   end

   // Idle burst length after a request, none in the calm tail
   function automatic int pick_gap();
      if (quiet_tail || !bursty || $urandom_range(0, 3) != 0)
         return 0;
      return $urandom_range(1, 15);
   endfunction

   // Present one request and hold it until it is taken
   task automatic push_request(logic op, logic signed [VALUE_W-1:0] value, logic last_flag);
      req_type r;
      int      gap;
      r.op    = op;
      r.value = value;
      r.last  = last_flag;
      gap     = pick_gap();
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      tracker.note_request(r);
      sent_count++;
      if (gap > 0) begin
         // junk on the data lines while start is low
         r.op    = 1'($urandom_range(0, 1));
         r.value = $urandom;
         r.last  = 1'($urandom_range(0, 1));
         start    <= 1'b0;
         req_data <= r;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Two ascending sets drawn from one walk so that they overlap
   task automatic run_sorted_pair();
      logic signed [VALUE_W-1:0] a_vals[$];
      logic signed [VALUE_W-1:0] b_vals[$];
      int      a_want;
      int      b_want;
      int      pick;
      longint  walk;
      longint  lo;
      longint  hi;
      longint unsigned span;
      bit      in_a;
      bit      in_b;
      bit      close_set;
      pick = $urandom_range(0, 99);
      if (pick < 6)
         a_want = $urandom_range(SET_CAP - 4, SET_CAP + 6);
      else if (pick < 10)
         a_want = 0;
      else
         a_want = $urandom_range(1, 12);
      b_want = $urandom_range(1, 12);
      // keep the whole walk inside the signed range
      lo = -(longint'(1) << 31);
      hi = (longint'(1) << 31) - 1 - 3 * (a_want + b_want);
      case ($urandom_range(0, 5))
         0: walk = lo;
         1: walk = hi;
         default: begin
            span = {$urandom, $urandom};
            walk = lo + longint'(span % longint'(hi - lo + 1));
         end
      endcase
      while (a_vals.size() < a_want || b_vals.size() < b_want) begin
         in_a = a_vals.size() < a_want && $urandom_range(0, 2) != 0;
         in_b = b_vals.size() < b_want && $urandom_range(0, 2) != 0;
         if (!in_a && !in_b) begin
            if (a_vals.size() < a_want)
               in_a = 1'b1;
            else
               in_b = 1'b1;
         end
         if (in_a)
            a_vals.insert(a_vals.size(), VALUE_W'(walk));
         if (in_b)
            b_vals.insert(b_vals.size(), VALUE_W'(walk));
         // an occasional zero step gives repeated elements
         walk += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
      end
      close_set = $urandom_range(0, 9) != 0;
      foreach (a_vals[i])
         push_request(OP_APPEND, a_vals[i], $urandom_range(0, 7) == 0);
      foreach (b_vals[i])
         push_request(OP_PROBE, b_vals[i], close_set && i == b_vals.size() - 1);
   endtask

   // Unordered and mixed requests with full-range values
   task automatic run_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n)
         push_request(1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 3) == 0);
   endtask

   initial begin
      tracker     = new();
      sent_count  = 0;
      cycle_count = 0;
      bursty      = 1'b1;
      quiet_tail  = 1'b0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // probes against an empty store, with and without last
      push_request(OP_PROBE, 32'sd42, 1'b0);
      push_request(OP_PROBE, -32'sd42, 1'b1);

      // extreme values; last on an append is ignored
      push_request(OP_APPEND, VAL_MIN, 1'b0);
      push_request(OP_APPEND, -32'sd1, 1'b0);
      push_request(OP_APPEND, 32'sd0, 1'b0);
      push_request(OP_APPEND, 32'sd5, 1'b1);
      push_request(OP_APPEND, VAL_MAX, 1'b0);
      push_request(OP_PROBE, VAL_MIN, 1'b0);
      push_request(OP_PROBE, -32'sd5, 1'b0);
      push_request(OP_PROBE, -32'sd1, 1'b0);
      push_request(OP_PROBE, 32'sd3, 1'b0);
      push_request(OP_PROBE, VAL_MAX, 1'b1);

      // repeated elements: each stored entry matches once
      push_request(OP_APPEND, 32'sd7, 1'b0);
      push_request(OP_APPEND, 32'sd7, 1'b0);
      push_request(OP_PROBE, 32'sd7, 1'b0);
      push_request(OP_PROBE, 32'sd7, 1'b0);
      push_request(OP_PROBE, 32'sd7, 1'b1);

      // random part: mostly well-formed set pairs, some noise
      while (sent_count < ITEM_TARGET) begin
         quiet_tail = sent_count >= ITEM_TARGET - CALM_TAIL;
         bursty     = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 99) < 85)
            run_sorted_pair();
         else
            run_noise();
      end
      start <= 1'b0;

      // drain outstanding results, then watch for strays
      while (tracker.awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.fail_count == 0 && tracker.awaited_results.size() == 0)
         $display("** sorted_set_intersection: PASSED **");
      else
         $display("** sorted_set_intersection: FAILED **");
      $finish;
   end

endmodule
